[hdl/sha224_pkg.sv]
// ----------------------------------------------------------------------------
// sha224_pkg
// Shared types, sequencer states, round constants and SHA-2 helper functions
// for the SHA-224 stream hasher.
// ----------------------------------------------------------------------------
package sha224_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] work_t;   // index 0 is variable a, 7 is h

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHEAD,
    ST_PZERO,
    ST_PLENHI,
    ST_PLENLO,
    ST_CLOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_ORD,
    ST_OLD,
    ST_OHOLD
  } state_e;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam int unsigned NumWords = 7;

  // round constants
  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial chaining value
  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'hc1059ed8;
      3'd1: r = 32'h367cd507;
      3'd2: r = 32'h3070dd17;
      3'd3: r = 32'hf70e5939;
      3'd4: r = 32'hffc00b31;
      3'd5: r = 32'h68581511;
      3'd6: r = 32'h64f98fa7;
      default: r = 32'hbefa4fa4;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hdl/sha224_if.sv]
// ----------------------------------------------------------------------------
// sha224_if
// Valid/ready channels of the SHA-224 stream hasher: message bytes in,
// digest words out.
// ----------------------------------------------------------------------------
interface sha224_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       last;

  modport source (output valid, output byte_value, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input byte_value, input has_byte, input last,
                  output ready);
endinterface

interface sha224_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

[hdl/sha224_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha224_stream_hasher
// SHA-224 over a byte stream: bytes are packed into a 16-word block memory,
// compressed one round per cycle, and the chaining words live in an 8-word
// memory that is read, updated and written back around each block.
// ----------------------------------------------------------------------------
// byte items: one per cycle while idle; the 64th byte of a block starts a compression
//   (chaining-word reads, 64 rounds, read-modify-write of the chaining words)
// final item: padding takes 3 to 18 memory writes, then one or two compressions,
//   then seven digest words, paced by the sink
// reset: asynchronous, active low; chaining words read as the initial value
//   through per-word valid bits, so no clearing pass is needed
module sha224_stream_hasher (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha224_in_if.sink     in_i,
  sha224_out_if.source  out_o
);
  import sha224_pkg::*;

  state_e        state_q, state_d;
  logic [3:0]    cnt_q;
  logic [5:0]    rnd_q;
  logic [4:0]    pw_q;
  logic [5:0]    fill_q;
  logic [63:0]   bits_q;
  logic [2:0][7:0] pack_q;
  logic          pend_q, two_q, fin_q;
  logic [7:0]    vld_q;
  work_t         work_q;
  work_t         round_w;
  word_t         sch_q [16];
  word_t         w_w;

  // block and chaining memories
  word_t         blk_mem [16];
  word_t         blk_rd_q;
  word_t         chain_mem [8];
  word_t         chain_mem_rd_q;
  logic          chain_vsel_q;
  logic [2:0]    chain_addr_q;
  word_t         chain_rd;

  // output register
  logic          out_vld_q;
  word_t         out_word_q;
  logic [2:0]    out_idx_q;

  // control outputs
  logic          in_rdy;
  logic          in_acc;
  logic          out_acc;
  logic          blk_we;
  logic [3:0]    blk_waddr;
  word_t         blk_wdata;
  logic [3:0]    blk_raddr;
  logic [2:0]    ch_raddr;
  logic          ch_we;
  logic [2:0]    ch_waddr;
  word_t         ch_wdata;
  word_t         head_word;
  logic [4:0]    pad_lim;
  logic          blk_full;

  assign in_acc   = in_i.valid & in_rdy;
  assign out_acc  = out_vld_q & out_o.ready;
  assign in_i.ready = in_rdy;
  assign blk_full = in_i.has_byte && (fill_q == 6'd63);
  assign pad_lim  = two_q ? 5'd16 : 5'd14;

  assign out_o.valid       = out_vld_q;
  assign out_o.digest_word = out_word_q;
  assign out_o.word_index  = out_idx_q;
  assign out_o.last_word   = (out_idx_q == 3'(NumWords - 1));

  // first padding word: buffered bytes, then the marker byte, then zeros
  always_comb begin
    head_word[31:24] = (fill_q[1:0] == 2'd0) ? PadByte : pack_q[0];
    head_word[23:16] = (fill_q[1:0] <  2'd1) ? 8'h00 :
                       (fill_q[1:0] == 2'd1) ? PadByte : pack_q[1];
    head_word[15:8]  = (fill_q[1:0] <  2'd2) ? 8'h00 :
                       (fill_q[1:0] == 2'd2) ? PadByte : pack_q[2];
    head_word[7:0]   = (fill_q[1:0] == 2'd3) ? PadByte : 8'h00;
  end

  // chaining word read: unwritten entries read as the initial value
  assign chain_rd = chain_vsel_q ? chain_mem_rd_q : iv_word(chain_addr_q);

  // message schedule word
  assign w_w = (rnd_q < 6'd16) ? blk_rd_q :
               small_sig1(sch_q[14]) + sch_q[9] + small_sig0(sch_q[1]) + sch_q[0];

  sha224_round u_round (
    .work_i (work_q),
    .w_i    (w_w),
    .k_i    (RoundK[rnd_q]),
    .work_o (round_w)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_full)            state_d = ST_CLOAD;
          else if (in_i.last)      state_d = ST_PHEAD;
        end
      end
      ST_PHEAD:  state_d = ST_PZERO;
      ST_PZERO: begin
        if (pw_q >= pad_lim) state_d = two_q ? ST_CLOAD : ST_PLENHI;
      end
      ST_PLENHI: state_d = ST_PLENLO;
      ST_PLENLO: state_d = ST_CLOAD;
      ST_CLOAD: begin
        if (cnt_q == 4'd8) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == 6'd63) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cnt_q == 4'd8) begin
          priority if (fin_q) state_d = ST_ORD;
          else if (two_q)     state_d = ST_PZERO;
          else if (pend_q)    state_d = ST_PHEAD;
          else                state_d = ST_IDLE;
        end
      end
      ST_ORD:  state_d = ST_OLD;
      ST_OLD:  state_d = ST_OHOLD;
      ST_OHOLD: begin
        if (out_acc) state_d = (cnt_q[2:0] == 3'(NumWords - 1)) ? ST_IDLE : ST_ORD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_rdy    = 1'b0;
    blk_we    = 1'b0;
    blk_waddr = '0;
    blk_wdata = '0;
    blk_raddr = '0;
    ch_raddr  = cnt_q[2:0];
    ch_we     = 1'b0;
    ch_waddr  = '0;
    ch_wdata  = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_acc && in_i.has_byte && (fill_q[1:0] == 2'd3)) begin
          blk_we    = 1'b1;
          blk_waddr = fill_q[5:2];
          blk_wdata = {pack_q[0], pack_q[1], pack_q[2], in_i.byte_value};
        end
      end
      ST_PHEAD: begin
        blk_we    = 1'b1;
        blk_waddr = fill_q[5:2];
        blk_wdata = head_word;
      end
      ST_PZERO: begin
        if (pw_q < pad_lim) begin
          blk_we    = 1'b1;
          blk_waddr = pw_q[3:0];
        end
      end
      ST_PLENHI: begin
        blk_we    = 1'b1;
        blk_waddr = 4'd14;
        blk_wdata = bits_q[63:32];
      end
      ST_PLENLO: begin
        blk_we    = 1'b1;
        blk_waddr = 4'd15;
        blk_wdata = bits_q[31:0];
      end
      ST_ROUND: begin
        blk_raddr = rnd_q[3:0] + 4'd1;
      end
      ST_UPDATE: begin
        if (cnt_q != 4'd0) begin
          ch_we    = 1'b1;
          ch_waddr = 3'(cnt_q - 4'd1);
          ch_wdata = chain_rd + work_q[0];
        end
      end
      ST_CLOAD, ST_ORD, ST_OLD, ST_OHOLD: begin
      end
      default: begin
      end
    endcase
  end

  // block memory
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd_q <= blk_mem[blk_raddr];
  end

  // chaining memory
  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      chain_mem[ch_waddr] <= ch_wdata;
    end
    chain_mem_rd_q <= chain_mem[ch_raddr];
    chain_addr_q   <= ch_raddr;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rnd_q        <= '0;
      pw_q         <= '0;
      fill_q       <= '0;
      bits_q       <= '0;
      pend_q       <= 1'b0;
      two_q        <= 1'b0;
      fin_q        <= 1'b0;
      vld_q        <= '0;
      chain_vsel_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      chain_vsel_q <= vld_q[ch_raddr];

      // step counter for memory sweeps and output words
      unique case (state_q)
        ST_CLOAD, ST_UPDATE: cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
        ST_ORD, ST_OLD:      cnt_q <= cnt_q;
        ST_OHOLD: begin
          if (out_acc) cnt_q <= (cnt_q[2:0] == 3'(NumWords - 1)) ? 4'd0 : cnt_q + 4'd1;
        end
        default:             cnt_q <= '0;
      endcase

      rnd_q <= (state_q == ST_ROUND) ? rnd_q + 6'd1 : 6'd0;

      // byte intake
      if (in_acc) begin
        pend_q <= in_i.last && blk_full;
        if (in_i.has_byte) begin
          fill_q <= fill_q + 6'd1;
          bits_q <= bits_q + 64'd8;
        end
      end

      // padding word pointer
      if (state_q == ST_PHEAD) begin
        pw_q  <= {1'b0, fill_q[5:2]} + 5'd1;
        two_q <= (fill_q >= 6'd56);
      end else if (state_q == ST_PZERO && pw_q < pad_lim) begin
        pw_q <= pw_q + 5'd1;
      end else if (state_q == ST_UPDATE && cnt_q == 4'd8) begin
        pw_q   <= '0;
        two_q  <= 1'b0;
        pend_q <= 1'b0;
      end

      if (state_q == ST_PLENLO) fin_q <= 1'b1;

      if (ch_we) vld_q[ch_waddr] <= 1'b1;

      // output register handshake and restart after the final word
      if (state_q == ST_OLD) begin
        out_vld_q <= 1'b1;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
        if (cnt_q[2:0] == 3'(NumWords - 1)) begin
          fill_q <= '0;
          bits_q <= '0;
          vld_q  <= '0;
          fin_q  <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.has_byte && (fill_q[1:0] != 2'd3)) begin
      pack_q[fill_q[1:0]] <= in_i.byte_value;
    end

    unique case (state_q)
      ST_CLOAD: begin
        if (cnt_q != 4'd0) work_q <= {chain_rd, work_q[7:1]};
      end
      ST_ROUND: begin
        work_q <= round_w;
      end
      ST_UPDATE: begin
        if (cnt_q != 4'd0) work_q <= {work_q[0], work_q[7:1]};
      end
      default: begin
      end
    endcase

    // schedule window shift
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sch_q[i] <= sch_q[i + 1];
      end
      sch_q[15] <= w_w;
    end

    if (state_q == ST_OLD) begin
      out_word_q <= chain_rd;
      out_idx_q  <= cnt_q[2:0];
    end
  end

endmodule

[hdl/sha224_round.sv]
// ----------------------------------------------------------------------------
// sha224_round
// One SHA-2 compression round: updates the eight working variables from the
// schedule word and the round constant.
// ----------------------------------------------------------------------------
module sha224_round (
  input  sha224_pkg::work_t work_i,
  input  sha224_pkg::word_t w_i,
  input  sha224_pkg::word_t k_i,
  output sha224_pkg::work_t work_o
);
  import sha224_pkg::*;

  word_t ch_w;
  word_t maj_w;
  word_t t1_w;
  word_t t2_w;

  // choose and majority
  assign ch_w  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
  assign maj_w = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);

  // round temporaries
  assign t1_w = work_i[7] + big_sig1(work_i[4]) + ch_w + k_i + w_i;
  assign t2_w = big_sig0(work_i[0]) + maj_w;

  // rotate variables
  always_comb begin
    work_o[0] = t1_w + t2_w;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1_w;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];
  end

endmodule
